>>> rtl/vbkf_pkg.sv
// shared types, widths and helpers for the velocity and bias filter
// no dependencies
package vbkf_pkg;

  // time step fraction bits
  localparam int DT_BITS = 24;

  // multiplier operand and result widths (result covers shifts of 16 or more)
  localparam int MA_W  = 35;
  localparam int MB_W  = 33;
  localparam int MR_W  = 56;
  // width of the exact sums ahead of saturation
  localparam int SUM_W = 58;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic        [23:0] time_step;
  } item_t;

  typedef struct packed {
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] bias_x;
    logic signed [31:0] bias_y;
  } result_t;

  // command codes
  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(SUM_W'(64'sd2147483647))) begin
      r = 32'sh7fffffff;
    end else if (v < $signed(-SUM_W'(64'sd2147483648))) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/velocity_bias_kalman_filter_core.sv
// velocity and accelerometer-bias kalman filter, two axes, signed fixed point
// depends on vbkf_pkg, vbkf_mul and vbkf_div
//
// Each item is either a predict (cmd 0: value_x/value_y are accelerations,
// time_step is dt) or an update (cmd 1: value_x/value_y are measured
// velocities). The block handles one item at a time: the X axis is worked
// through first, then the Y axis, on one shared multiplier under a small
// step sequencer. A predict works through the multiplier steps for each
// axis. An update runs two gain divisions per axis on a bit-serial divider
// (a saturating gain skips its serial steps) after a divisor check and then
// the multiplier steps; an axis whose gain divisor is not positive is
// skipped at the check. The result item is held in an output register, so
// the next item is taken while it waits. Configuration registers may be
// written only while the block is idle.
module velocity_bias_kalman_filter_core #(
  parameter int FRAC_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  vbkf_pkg::item_t       item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output vbkf_pkg::result_t     result,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [30:0]           cfg_data
);

  localparam int SW = vbkf_pkg::SUM_W;

  // register indexes
  localparam logic [1:0] REG_QV = 2'd0;
  localparam logic [1:0] REG_QB = 2'd1;
  localparam logic [1:0] REG_R  = 2'd2;

  // reset values of the noise registers: 0.002, 0.006 and 0.01
  localparam logic [30:0] QV_RESET = 31'(((64'd2 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [30:0] QB_RESET = 31'(((64'd6 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [30:0] R_RESET  = 31'(((64'd10 << FRAC_BITS) + 64'd500) / 64'd1000);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_UCHK = 3'd2;
  localparam logic [2:0] ST_DIV0 = 3'd3;
  localparam logic [2:0] ST_DIV1 = 3'd4;
  localparam logic [2:0] ST_UMUL = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state;
  logic [2:0] step;
  logic       axis;

  // configuration
  logic [30:0] qv;
  logic [30:0] qb;
  logic [30:0] rn;

  // filter state, one entry per axis; covariance entries p00, p01, p10, p11
  logic signed [31:0] vel  [2];
  logic signed [31:0] bias [2];
  logic signed [31:0] pc   [2][4];

  // captured item
  logic signed [31:0] meas [2];
  logic        [23:0] dt_r;

  // working registers
  logic signed [31:0] tmp;
  logic signed [32:0] y;
  logic signed [31:0] k0;
  logic signed [31:0] k1;

  // shared multiplier
  logic signed [vbkf_pkg::MA_W-1:0] mul_a;
  logic signed [vbkf_pkg::MB_W-1:0] mul_b;
  logic                             mul_frac;
  logic signed [vbkf_pkg::MR_W-1:0] prod;

  // divider
  logic               div_start;
  logic signed [31:0] div_num;
  logic               div_done;
  logic signed [31:0] div_q;

  // current axis values and the candidate new values
  logic signed [31:0] v_c, b_c, p0, p1, p2, p3;
  logic signed [SW-1:0] prod_w, s_w, inner_w, accb_w, y_w;
  logic               s_pos;
  logic signed [31:0] v_plus, b_plus, p00_plus, p00_minus, p11_plus, p11_minus;
  logic signed [31:0] p10_minus, p01_minus, p01_mt, p10_mt;
  logic               accept;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    v_c    = vel[axis];
    b_c    = bias[axis];
    p0     = pc[axis][0];
    p1     = pc[axis][1];
    p2     = pc[axis][2];
    p3     = pc[axis][3];
    prod_w = SW'(prod);
    // gain divisor s = p00 + r
    s_w    = SW'(p0) + $signed(SW'({1'b0, rn}));
    s_pos  = !s_w[SW-1] && (s_w != '0);
    // predict inner term: p11*dt + qv - p01 - p10
    inner_w = prod_w + $signed(SW'({1'b0, qv})) - SW'(p1) - SW'(p2);
    accb_w  = SW'(meas[axis]) - SW'(b_c);
    y_w     = SW'(meas[axis]) - SW'(v_c);

    v_plus    = vbkf_pkg::sat32(SW'(v_c) + prod_w);
    b_plus    = vbkf_pkg::sat32(SW'(b_c) + prod_w);
    p00_plus  = vbkf_pkg::sat32(SW'(p0) + prod_w);
    p00_minus = vbkf_pkg::sat32(SW'(p0) - prod_w);
    p01_minus = vbkf_pkg::sat32(SW'(p1) - prod_w);
    p10_minus = vbkf_pkg::sat32(SW'(p2) - prod_w);
    p11_plus  = vbkf_pkg::sat32(SW'(p3) + prod_w);
    p11_minus = vbkf_pkg::sat32(SW'(p3) - prod_w);
    p01_mt    = vbkf_pkg::sat32(SW'(p1) - SW'(tmp));
    p10_mt    = vbkf_pkg::sat32(SW'(p2) - SW'(tmp));
  end

  // multiplier operand selection per step
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_frac = 1'b0;
    if (state == ST_PRED) begin
      mul_b = vbkf_pkg::MB_W'({1'b0, dt_r});
      unique case (step)
        3'd0:    mul_a = accb_w[vbkf_pkg::MA_W-1:0];
        3'd1:    mul_a = vbkf_pkg::MA_W'(p3);
        3'd2:    mul_a = inner_w[vbkf_pkg::MA_W-1:0];
        3'd3:    mul_a = vbkf_pkg::MA_W'({1'b0, qb});
        default: mul_a = '0;
      endcase
    end else if (state == ST_UMUL) begin
      mul_frac = 1'b1;
      unique case (step)
        3'd0:    begin mul_a = vbkf_pkg::MA_W'(y);  mul_b = vbkf_pkg::MB_W'(k0); end
        3'd1:    begin mul_a = vbkf_pkg::MA_W'(y);  mul_b = vbkf_pkg::MB_W'(k1); end
        3'd2:    begin mul_a = vbkf_pkg::MA_W'(p0); mul_b = vbkf_pkg::MB_W'(k1); end
        3'd3:    begin mul_a = vbkf_pkg::MA_W'(p0); mul_b = vbkf_pkg::MB_W'(k0); end
        3'd4:    begin mul_a = vbkf_pkg::MA_W'(p1); mul_b = vbkf_pkg::MB_W'(k1); end
        3'd5:    begin mul_a = vbkf_pkg::MA_W'(p1); mul_b = vbkf_pkg::MB_W'(k0); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // divider launches: first gain from the check state, second on first done
  always_comb begin
    div_start = 1'b0;
    div_num   = p0;
    if (state == ST_UCHK && s_pos) begin
      div_start = 1'b1;
    end else if (state == ST_DIV0 && div_done) begin
      div_start = 1'b1;
      div_num   = p2;
    end
  end

  vbkf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk        (clk),
    .a          (mul_a),
    .b          (mul_b),
    .frac_shift (mul_frac),
    .prod       (prod)
  );

  vbkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (s_w[31:0]),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      axis         <= 1'b0;
      result_valid <= 1'b0;
      qv           <= QV_RESET;
      qb           <= QB_RESET;
      rn           <= R_RESET;
      for (int i = 0; i < 2; i++) begin
        vel[i]  <= '0;
        bias[i] <= '0;
        for (int j = 0; j < 4; j++) begin
          pc[i][j] <= '0;
        end
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_QV:  qv <= cfg_data;
          REG_QB:  qb <= cfg_data;
          REG_R:   rn <= cfg_data;
          default: ;
        endcase
      end

      // the output state reloads the result register itself
      if (result_valid && !result_stall && state != ST_OUT) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            meas[0] <= item.value_x;
            meas[1] <= item.value_y;
            dt_r    <= item.time_step;
            axis    <= 1'b0;
            step    <= '0;
            state   <= (item.cmd == vbkf_pkg::CMD_UPDATE) ? ST_UCHK : ST_PRED;
          end
        end

        ST_PRED: begin
          step <= (step == 3'd4) ? 3'd0 : step + 3'd1;
          unique case (step)
            3'd1:    vel[axis] <= v_plus;
            3'd2:    tmp <= prod[31:0];
            3'd3:    pc[axis][0] <= p00_plus;
            3'd4: begin
              pc[axis][3] <= p11_plus;
              pc[axis][1] <= p01_mt;
              pc[axis][2] <= p10_mt;
              if (axis == 1'b0) begin
                axis  <= 1'b1;
              end else begin
                state <= ST_OUT;
              end
            end
            default: ;
          endcase
        end

        ST_UCHK: begin
          y <= y_w[32:0];
          if (s_pos) begin
            state <= ST_DIV0;
          end else if (axis == 1'b0) begin
            axis <= 1'b1;
          end else begin
            state <= ST_OUT;
          end
        end

        ST_DIV0: begin
          if (div_done) begin
            k0    <= div_q;
            state <= ST_DIV1;
          end
        end

        ST_DIV1: begin
          if (div_done) begin
            k1    <= div_q;
            step  <= '0;
            state <= ST_UMUL;
          end
        end

        ST_UMUL: begin
          step <= (step == 3'd6) ? 3'd0 : step + 3'd1;
          unique case (step)
            3'd1:    vel[axis]   <= v_plus;
            3'd2:    bias[axis]  <= b_plus;
            3'd3:    pc[axis][2] <= p10_minus;
            3'd4:    pc[axis][0] <= p00_minus;
            3'd5:    pc[axis][3] <= p11_minus;
            3'd6: begin
              pc[axis][1] <= p01_minus;
              if (axis == 1'b0) begin
                axis  <= 1'b1;
                state <= ST_UCHK;
              end else begin
                state <= ST_OUT;
              end
            end
            default: ;
          endcase
        end

        ST_OUT: begin
          // load the result register once the previous item has been taken
          if (!result_valid || !result_stall) begin
            result.velocity_x <= vel[0];
            result.velocity_y <= vel[1];
            result.bias_x     <= bias[0];
            result.bias_y     <= bias[1];
            result_valid      <= 1'b1;
            state             <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/vbkf_mul.sv
// shared signed multiply with round-to-nearest (ties away) rescale
// depends on vbkf_pkg
module vbkf_mul #(
  parameter int FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic signed [vbkf_pkg::MA_W-1:0]  a,
  input  logic signed [vbkf_pkg::MB_W-1:0]  b,
  input  logic                              frac_shift,
  output logic signed [vbkf_pkg::MR_W-1:0]  prod
);

  localparam int PW = vbkf_pkg::MA_W + vbkf_pkg::MB_W;

  logic [vbkf_pkg::MA_W-1:0] ma;
  logic [vbkf_pkg::MB_W-1:0] mb;
  logic [PW-1:0]             m;
  logic [PW-1:0]             r;
  logic                      neg;

  always_comb begin
    ma  = a[vbkf_pkg::MA_W-1] ? vbkf_pkg::MA_W'(-a) : vbkf_pkg::MA_W'(a);
    mb  = b[vbkf_pkg::MB_W-1] ? vbkf_pkg::MB_W'(-b) : vbkf_pkg::MB_W'(b);
    neg = a[vbkf_pkg::MA_W-1] ^ b[vbkf_pkg::MB_W-1];
    m   = PW'(ma) * PW'(mb);
    if (frac_shift) begin
      r = (m + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    end else begin
      r = (m + (PW'(1) << (vbkf_pkg::DT_BITS - 1))) >> vbkf_pkg::DT_BITS;
    end
  end

  always_ff @(posedge clk) begin
    prod <= neg ? -$signed(r[vbkf_pkg::MR_W-1:0]) : $signed(r[vbkf_pkg::MR_W-1:0]);
  end

endmodule

>>> rtl/vbkf_div.sv
// bit-serial rounded gain divider, saturating to the signed 32-bit range
// no dependencies; self-contained logic
module vbkf_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic        [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  localparam int NW = 32 + FRAC_BITS + 1;

  logic [31:0]   nmag;
  logic [NW-1:0] n_full;
  logic [63:0]   hi;
  logic          sat_now;

  logic          busy;
  logic          neg;
  logic          sat;
  logic [31:0]   rem;
  logic [30:0]   lo;
  logic [30:0]   qbits;
  logic [4:0]    cnt;
  logic [32:0]   trial;
  logic          qbit;

  always_comb begin
    nmag    = num[31] ? 32'(-num) : 32'(num);
    n_full  = (NW'(nmag) << FRAC_BITS) + NW'(den >> 1);
    hi      = 64'(n_full >> 31);
    sat_now = hi >= 64'(den);
    trial   = {rem, lo[30]};
    qbit    = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg   <= num[31];
        sat   <= sat_now;
        rem   <= hi[31:0];
        lo    <= n_full[30:0];
        qbits <= '0;
        cnt   <= 5'd30;
        busy  <= !sat_now;
        done  <= sat_now;
      end else if (busy) begin
        rem   <= qbit ? 32'(trial - {1'b0, den}) : trial[31:0];
        lo    <= {lo[29:0], 1'b0};
        qbits <= {qbits[29:0], qbit};
        cnt   <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (sat) begin
      quot = neg ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      quot = neg ? -$signed({1'b0, qbits}) : $signed({1'b0, qbits});
    end
  end

endmodule

>>> tb/velocity_bias_kalman_filter_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the two-axis velocity and bias kalman filter core
// depends on vbkf_pkg and velocity_bias_kalman_filter_core
module velocity_bias_kalman_filter_core_tb;

  localparam int FRAC      = 24;
  localparam int IDX_QV    = 0;
  localparam int IDX_QB    = 1;
  localparam int IDX_R     = 2;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 830;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  vbkf_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  vbkf_pkg::result_t result;
  logic              cfg_write = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [30:0]       cfg_data = '0;

  always #6 clk = ~clk;

  velocity_bias_kalman_filter_core #(.FRAC_BITS(FRAC)) dut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid,
    .result_stall, .result, .cfg_write, .cfg_index, .cfg_data
  );

  // predictor state: per axis velocity, bias and covariance p00 p01 p10 p11
  longint est_vel[2], est_bias[2];
  longint cov[2][4];
  longint noise_qv, noise_qb, noise_r;

  vbkf_pkg::result_t estimate_q[$];
  int      errors = 0;
  int      n_items = 0, n_results = 0, n_predict = 0, n_update = 0;
  int      watchdog = 0;
  bit      long_hold = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // rounded product, ties away from zero
  function automatic longint rmul(longint a, longint b, int sh);
    longint unsigned m;
    bit neg;
    neg = (a < 0) != (b < 0);
    m = (longint'(abs64(a)) * longint'(abs64(b)));
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint rdiv(longint num, longint den);
    longint unsigned q;
    q = ((longint'(abs64(num)) << FRAC) + den / 2) / den;
    if (q > 64'h80000000) q = 64'h80000000;
    return clamp32(num < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic void predict_axis(int ax, longint acc, longint dt);
    longint p00, p01, p10, p11, inner;
    p00 = cov[ax][0]; p01 = cov[ax][1]; p10 = cov[ax][2]; p11 = cov[ax][3];
    est_vel[ax] = clamp32(est_vel[ax] + rmul(dt, acc - est_bias[ax], vbkf_pkg::DT_BITS));
    inner = rmul(p11, dt, vbkf_pkg::DT_BITS) + noise_qv - p01 - p10;
    cov[ax][0] = clamp32(p00 + rmul(inner, dt, vbkf_pkg::DT_BITS));
    cov[ax][1] = clamp32(p01 - rmul(dt, p11, vbkf_pkg::DT_BITS));
    cov[ax][2] = clamp32(p10 - rmul(dt, p11, vbkf_pkg::DT_BITS));
    cov[ax][3] = clamp32(p11 + rmul(dt, noise_qb, vbkf_pkg::DT_BITS));
  endfunction

  function automatic void correct_axis(int ax, longint meas);
    longint p00, p01, p10, p11, s, y, k0, k1;
    p00 = cov[ax][0]; p01 = cov[ax][1]; p10 = cov[ax][2]; p11 = cov[ax][3];
    s = p00 + noise_r;
    y = meas - est_vel[ax];
    // nonpositive divisor leaves the axis untouched
    if (s <= 0) return;
    k0 = rdiv(p00, s);
    k1 = rdiv(p10, s);
    est_vel[ax]  = clamp32(est_vel[ax] + rmul(k0, y, FRAC));
    est_bias[ax] = clamp32(est_bias[ax] + rmul(k1, y, FRAC));
    cov[ax][0] = clamp32(p00 - rmul(k0, p00, FRAC));
    cov[ax][1] = clamp32(p01 - rmul(k0, p01, FRAC));
    cov[ax][2] = clamp32(p10 - rmul(k1, p00, FRAC));
    cov[ax][3] = clamp32(p11 - rmul(k1, p01, FRAC));
  endfunction

  function automatic vbkf_pkg::result_t filter_step(vbkf_pkg::item_t it);
    vbkf_pkg::result_t r;
    if (it.cmd == vbkf_pkg::CMD_PREDICT) begin
      predict_axis(0, longint'(it.value_x), longint'(it.time_step));
      predict_axis(1, longint'(it.value_y), longint'(it.time_step));
    end else begin
      correct_axis(0, longint'(it.value_x));
      correct_axis(1, longint'(it.value_y));
    end
    r.velocity_x = est_vel[0][31:0];
    r.velocity_y = est_vel[1][31:0];
    r.bias_x     = est_bias[0][31:0];
    r.bias_y     = est_bias[1][31:0];
    return r;
  endfunction

  // directed table, expected result typed in only where it is obvious
  typedef struct {
    vbkf_pkg::item_t   it;
    bit                known;
    vbkf_pkg::result_t res;
  } row_t;

  row_t rows[$];

  function automatic vbkf_pkg::item_t mk(logic c, int vx, int vy, int dt);
    vbkf_pkg::item_t t;
    t.cmd = c; t.value_x = vx; t.value_y = vy; t.time_step = dt[23:0];
    return t;
  endfunction

  // expected results come from the predictor, or from the table
  task automatic send_item(vbkf_pkg::item_t it, bit known, vbkf_pkg::result_t res);
    vbkf_pkg::result_t e;
    int gap;
    e = filter_step(it);
    if (known) e = res;
    gap = $urandom_range(0, 14);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    estimate_q.push_back(e);
    n_items++;
    if (it.cmd == vbkf_pkg::CMD_PREDICT) n_predict++; else n_update++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (estimate_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [30:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx[1:0];
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      IDX_QV: noise_qv = longint'(val);
      IDX_QB: noise_qb = longint'(val);
      default: noise_r = longint'(val);
    endcase
    @(posedge clk);
  endtask

  function automatic int rand_value(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      default: return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
    endcase
  endfunction

  // receiver: random stall per item, one long hold-off when asked
  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        result_stall <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (w != 0) begin
        result_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!(result_valid && !result_stall)) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (estimate_q.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        vbkf_pkg::result_t e;
        e = estimate_q.pop_front();
        n_results++;
        if (result.velocity_x !== e.velocity_x) begin
          $error("velocity_x exp %0d got %0d", e.velocity_x, result.velocity_x);
          errors++;
        end
        if (result.velocity_y !== e.velocity_y) begin
          $error("velocity_y exp %0d got %0d", e.velocity_y, result.velocity_y);
          errors++;
        end
        if (result.bias_x !== e.bias_x) begin
          $error("bias_x exp %0d got %0d", e.bias_x, result.bias_x);
          errors++;
        end
        if (result.bias_y !== e.bias_y) begin
          $error("bias_y exp %0d got %0d", e.bias_y, result.bias_y);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || rst)
      watchdog <= 0;
    else
      watchdog <= watchdog + 1;
    if (watchdog >= WDOG_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    vbkf_pkg::result_t zero_res;
    vbkf_pkg::item_t   it;
    int                mode, run_len;
    zero_res = '0;
    noise_qv = 33554; noise_qb = 100663; noise_r = 167772;
    for (int a = 0; a < 2; a++) begin
      est_vel[a] = 0; est_bias[a] = 0;
      for (int k = 0; k < 4; k++) cov[a][k] = 0;
    end

    // update right after reset has zero gain, state stays zero
    rows.push_back('{mk(vbkf_pkg::CMD_UPDATE, 32'sh7fffffff, 32'sh80000000, 0),
                     1'b1, zero_res});
    // zero dt predict changes nothing
    rows.push_back('{mk(vbkf_pkg::CMD_PREDICT, 32'sh7fffffff, 32'sh80000000, 0),
                     1'b1, zero_res});
    rows.push_back('{mk(vbkf_pkg::CMD_PREDICT, 32'sh7fffffff, 32'sh80000000, 24'hffffff),
                     1'b0, zero_res});
    rows.push_back('{mk(vbkf_pkg::CMD_PREDICT, 32'sh7fffffff, 32'sh80000000, 24'hffffff),
                     1'b0, zero_res});
    rows.push_back('{mk(vbkf_pkg::CMD_UPDATE, 32'sh80000000, 32'sh7fffffff, 24'hffffff),
                     1'b0, zero_res});
    rows.push_back('{mk(vbkf_pkg::CMD_PREDICT, 32'sh01000000, -32'sh01000000, 24'h028f5c),
                     1'b0, zero_res});
    rows.push_back('{mk(vbkf_pkg::CMD_UPDATE, 32'sh00800000, -32'sh00800000, 0),
                     1'b0, zero_res});
    rows.push_back('{mk(vbkf_pkg::CMD_PREDICT, 0, 0, 24'h800000), 1'b0, zero_res});
    rows.push_back('{mk(vbkf_pkg::CMD_UPDATE, -1, 1, 24'h000001), 1'b0, zero_res});
    for (int k = 0; k < 12; k++)
      rows.push_back('{mk(k[0], 32'sh7fffffff, 32'sh7fffffff, 24'hffffff), 1'b0, zero_res});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].it, rows[i].known, rows[i].res);
    drain();

    // largest noises, saturated covariance, then nonpositive divisor with r at zero
    write_reg(IDX_QV, 31'h7fffffff);
    write_reg(IDX_QB, 31'h7fffffff);
    write_reg(IDX_R, 31'h7fffffff);
    for (int k = 0; k < 4; k++)
      send_item(mk(k[0], rand_value(0), rand_value(0), $urandom_range(0, 24'hffffff)),
                1'b0, zero_res);
    drain();
    write_reg(IDX_QV, 31'd0);
    write_reg(IDX_QB, 31'd0);
    write_reg(IDX_R, 31'd0);
    for (int k = 0; k < 4; k++)
      send_item(mk(k[0], rand_value(0), rand_value(0), $urandom_range(0, 24'hffffff)),
                1'b0, zero_res);
    drain();

    // random phases with fresh register settings; sender pause between phases
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(IDX_QV, (ph == 0) ? 31'd33554 : 31'($urandom_range(0, 32'h00ffffff)));
      write_reg(IDX_QB, (ph == 0) ? 31'd100663 : 31'($urandom_range(0, 32'h00ffffff)));
      write_reg(IDX_R, (ph == 5) ? 31'd1 :
                       (ph == 4) ? 31'h7fffffff : 31'($urandom_range(1, 32'h01ffffff)));
      if (ph == 2) long_hold = 1'b1;
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        mode = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
        run_len = $urandom_range(0, 3);
        it = mk(1'($urandom_range(0, 1)), rand_value(mode), rand_value(mode),
                (mode == 0) ? $urandom_range(0, 24'hffffff) : $urandom_range(0, 24'h080000));
        if (run_len == 0) it.time_step = 24'($urandom_range(0, 24'hffffff));
        send_item(it, 1'b0, zero_res);
      end
      drain();
    end

    $display("covered %0d items (%0d predict, %0d update), %0d results checked",
             n_items, n_predict, n_update, n_results);
    $display("register settings included zero, one and full-scale noises");
    if (errors == 0 && estimate_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
